// ===== hdl/pleng_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pleng_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package pleng_pkg;

    localparam logic [2:0] OP_APPEND_TAIL = 3'd0;
    localparam logic [2:0] OP_INSERT_HEAD = 3'd1;
    localparam logic [2:0] OP_INSERT_POS  = 3'd2;
    localparam logic [2:0] OP_REMOVE_HEAD = 3'd3;
    localparam logic [2:0] OP_REMOVE_TAIL = 3'd4;
    localparam logic [2:0] OP_REMOVE_POS  = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [15:0]        position;
        logic signed [31:0] element_value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [8:0]         list_length;
    } out_t;

endpackage
`default_nettype wire

// ===== hdl/positional_list_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded circular singly linked list of signed words kept in a link memory
// and a value memory, with a free chain of unused slots.
// ----------------------------------------------------------------------------
//  channel  | ports                      | moves
//  ---------+----------------------------+---------------------------------
//  request  | s_valid s_ready s_data     | opcode, position, element_value
//  result   | m_valid m_ready m_data     | removed_value, status, list_length
//
//  refusals and unused codes are answered from S_IDLE; head inserts and
//  appends pass S_INS_A (enough for an empty list) and S_INS_B, head removal
//  S_RH and S_GIVE; positional ops and tail removal walk the link memory one
//  link per cycle. after reset a clearing pass chains every slot into the free
//  list; no request is taken during it. one request is in work at a time; a
//  result waiting in the output register holds off the next request until taken.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire pleng_pkg::in_t   s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output pleng_pkg::out_t       m_data
);

    localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 16) ? CW : 16) + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_INS_A, S_INS_B, S_WALK, S_NEXT,
        S_LINK, S_UNLINK, S_RH, S_GIVE
    } state_t;

    typedef enum logic [2:0] {
        K_IHEAD, K_ITAIL, K_IMID, K_RHEAD, K_RTAIL, K_RMID
    } kind_t;

    state_t                  state_reg, state_next;
    kind_t                   kind_reg, kind_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           tail_reg, tail_next;
    logic [AW-1:0]           free_reg, free_next;
    logic [AW-1:0]           slot_reg, slot_next;
    logic [AW-1:0]           prev_reg, prev_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           steps_reg, steps_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    logic                    mval_reg, mval_next;
    pleng_pkg::out_t         mdata_reg, mdata_next;

    // link memory
    logic [AW-1:0] lk_mem [CAPACITY];
    logic          lk_we, lk_re;
    logic [AW-1:0] lk_wa, lk_wd, lk_ra, lk_rd;

    // value memory
    logic [VALUE_BITS-1:0]        vm_mem [CAPACITY];
    logic                         vm_we, vm_re;
    logic [AW-1:0]                vm_wa, vm_ra;
    logic signed [VALUE_BITS-1:0] vm_rd;

    always_ff @(posedge aclk) begin
        if (lk_we) begin
            lk_mem[lk_wa] <= lk_wd;
        end
        if (lk_re) begin
            lk_rd <= lk_mem[lk_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (vm_we) begin
            vm_mem[vm_wa] <= val_reg;
        end
        if (vm_re) begin
            vm_rd <= vm_mem[vm_ra];
        end
    end

    logic               accept;
    logic signed [63:0] in_ext, rd_ext;
    logic [PW-1:0]      pos_ext, cnt_ext, p_ins, p_rem;
    logic               full, empty;

    assign s_ready = (state_reg == S_IDLE) && (!mval_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = mval_reg;
    assign m_data  = mdata_reg;

    assign in_ext  = 64'(s_data.element_value);
    assign rd_ext  = 64'(vm_rd);
    assign pos_ext = PW'(s_data.position);
    assign cnt_ext = PW'(cnt_reg);
    assign p_ins   = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
    assign p_rem   = (pos_ext > cnt_ext - PW'(1)) ? cnt_ext - PW'(1) : pos_ext;
    assign full    = (cnt_reg == CW'(CAPACITY));
    assign empty   = (cnt_reg == '0);

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        slot_next  = slot_reg;
        prev_next  = prev_reg;
        clr_next   = clr_reg;
        cnt_next   = cnt_reg;
        steps_next = steps_reg;
        val_next   = val_reg;
        mval_next  = mval_reg && !m_ready;
        mdata_next = mdata_reg;
        lk_we = 1'b0;
        lk_wa = '0;
        lk_wd = '0;
        lk_re = 1'b0;
        lk_ra = '0;
        vm_we = 1'b0;
        vm_wa = free_reg;
        vm_re = 1'b0;
        vm_ra = '0;

        unique case (state_reg)
            S_CLEAR: begin
                lk_we = 1'b1;
                lk_wa = clr_reg;
                lk_wd = (clr_reg == AW'(CAPACITY - 1)) ? '0 : clr_reg + AW'(1);
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CAPACITY - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    val_next = in_ext[VALUE_BITS-1:0];
                    mdata_next.removed_value = '0;
                    mdata_next.list_length   = 9'(cnt_reg);
                    unique case (s_data.opcode) inside
                        pleng_pkg::OP_APPEND_TAIL, pleng_pkg::OP_INSERT_HEAD,
                        pleng_pkg::OP_INSERT_POS: begin
                            if (full) begin
                                mval_next         = 1'b1;
                                mdata_next.status = pleng_pkg::ST_FULL;
                            end else begin
                                lk_re      = 1'b1;
                                lk_ra      = free_reg;
                                state_next = S_INS_A;
                                steps_next = CW'(p_ins - PW'(1));
                                if (s_data.opcode == pleng_pkg::OP_APPEND_TAIL) begin
                                    kind_next = K_ITAIL;
                                end else if (s_data.opcode == pleng_pkg::OP_INSERT_HEAD ||
                                             p_ins == '0) begin
                                    kind_next = K_IHEAD;
                                end else if (p_ins == cnt_ext) begin
                                    kind_next = K_ITAIL;
                                end else begin
                                    kind_next = K_IMID;
                                end
                            end
                        end
                        pleng_pkg::OP_REMOVE_HEAD, pleng_pkg::OP_REMOVE_TAIL,
                        pleng_pkg::OP_REMOVE_POS: begin
                            if (empty) begin
                                mval_next         = 1'b1;
                                mdata_next.status = pleng_pkg::ST_EMPTY;
                            end else if (s_data.opcode == pleng_pkg::OP_REMOVE_HEAD ||
                                         cnt_reg == CW'(1) ||
                                         (s_data.opcode == pleng_pkg::OP_REMOVE_POS &&
                                          p_rem == '0)) begin
                                kind_next  = K_RHEAD;
                                slot_next  = head_reg;
                                lk_re      = 1'b1;
                                lk_ra      = head_reg;
                                vm_re      = 1'b1;
                                vm_ra      = head_reg;
                                state_next = S_RH;
                            end else begin
                                // walk from the head to the node before the victim
                                lk_re     = 1'b1;
                                lk_ra     = head_reg;
                                prev_next = head_reg;
                                if (s_data.opcode == pleng_pkg::OP_REMOVE_TAIL ||
                                    p_rem == cnt_ext - PW'(1)) begin
                                    kind_next  = K_RTAIL;
                                    slot_next  = tail_reg;
                                    vm_re      = 1'b1;
                                    vm_ra      = tail_reg;
                                    steps_next = cnt_reg - CW'(2);
                                end else begin
                                    kind_next  = K_RMID;
                                    steps_next = CW'(p_rem - PW'(1));
                                end
                                state_next = (steps_next == '0) ? S_NEXT : S_WALK;
                            end
                        end
                        default: begin
                            mval_next         = 1'b1;
                            mdata_next.status = pleng_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_INS_A: begin
                free_next = lk_rd;
                slot_next = free_reg;
                vm_we     = 1'b1;
                mdata_next.status = pleng_pkg::ST_DONE;
                if (kind_reg == K_IMID) begin
                    lk_re      = 1'b1;
                    lk_ra      = head_reg;
                    prev_next  = head_reg;
                    state_next = (steps_reg == '0) ? S_NEXT : S_WALK;
                end else if (empty) begin
                    lk_we      = 1'b1;
                    lk_wa      = free_reg;
                    lk_wd      = free_reg;
                    head_next  = free_reg;
                    tail_next  = free_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_IDLE;
                    mval_next  = 1'b1;
                    mdata_next.list_length = 9'(cnt_next);
                end else begin
                    lk_we      = 1'b1;
                    lk_wa      = (kind_reg == K_IHEAD) ? free_reg : tail_reg;
                    lk_wd      = (kind_reg == K_IHEAD) ? head_reg : free_reg;
                    state_next = S_INS_B;
                end
            end
            S_INS_B: begin
                lk_we = 1'b1;
                if (kind_reg == K_IHEAD) begin
                    lk_wa     = tail_reg;
                    lk_wd     = slot_reg;
                    head_next = slot_reg;
                end else begin
                    lk_wa     = slot_reg;
                    lk_wd     = head_reg;
                    tail_next = slot_reg;
                end
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_IDLE;
                mval_next  = 1'b1;
                mdata_next.list_length = 9'(cnt_next);
            end
            S_WALK: begin
                prev_next  = lk_rd;
                lk_re      = 1'b1;
                lk_ra      = lk_rd;
                steps_next = steps_reg - CW'(1);
                if (steps_reg == CW'(1)) begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                // lk_rd is the link of the node before the target
                case (kind_reg)
                    K_IMID: begin
                        lk_we      = 1'b1;
                        lk_wa      = slot_reg;
                        lk_wd      = lk_rd;
                        state_next = S_LINK;
                    end
                    K_RTAIL: begin
                        lk_we      = 1'b1;
                        lk_wa      = prev_reg;
                        lk_wd      = head_reg;
                        tail_next  = prev_reg;
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = S_GIVE;
                    end
                    default: begin
                        slot_next  = lk_rd;
                        lk_re      = 1'b1;
                        lk_ra      = lk_rd;
                        vm_re      = 1'b1;
                        vm_ra      = lk_rd;
                        state_next = S_UNLINK;
                    end
                endcase
            end
            S_LINK: begin
                lk_we      = 1'b1;
                lk_wa      = prev_reg;
                lk_wd      = slot_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_IDLE;
                mval_next  = 1'b1;
                mdata_next.list_length = 9'(cnt_next);
            end
            S_UNLINK: begin
                lk_we      = 1'b1;
                lk_wa      = prev_reg;
                lk_wd      = lk_rd;
                cnt_next   = cnt_reg - CW'(1);
                state_next = S_GIVE;
            end
            S_RH: begin
                if (cnt_reg == CW'(1)) begin
                    cnt_next = '0;
                end else begin
                    head_next = lk_rd;
                    lk_we     = 1'b1;
                    lk_wa     = tail_reg;
                    lk_wd     = lk_rd;
                    cnt_next  = cnt_reg - CW'(1);
                end
                state_next = S_GIVE;
            end
            S_GIVE: begin
                lk_we      = 1'b1;
                lk_wa      = slot_reg;
                lk_wd      = free_reg;
                free_next  = slot_reg;
                state_next = S_IDLE;
                mval_next  = 1'b1;
                mdata_next.removed_value = rd_ext[31:0];
                mdata_next.status        = pleng_pkg::ST_DONE;
                mdata_next.list_length   = 9'(cnt_reg);
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            head_reg  <= '0;
            tail_reg  <= '0;
            free_reg  <= '0;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            mval_reg  <= mval_next;
        end
        kind_reg  <= kind_next;
        slot_reg  <= slot_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        val_reg   <= val_next;
        mdata_reg <= mdata_next;
    end

    // a store-full refusal only happens at capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mval_reg && mdata_reg.status == pleng_pkg::ST_FULL)
            |-> (cnt_reg == CW'(CAPACITY)))
        else $error("full status below capacity");

    // an empty refusal reports a zero length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mval_reg && mdata_reg.status == pleng_pkg::ST_EMPTY)
            |-> (mdata_reg.list_length == '0))
        else $error("empty status with nonzero length");

    // length moves by at most one per request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_CLEAR && $past(state_reg) != S_CLEAR)
            |-> (cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + CW'(1) ||
                 $past(cnt_reg) == cnt_reg + CW'(1)))
        else $error("length jumped");

    // an accepted request leaves S_IDLE or raises a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE || mval_reg))
        else $error("request produced no work");

endmodule
`default_nettype wire
